// File: design/ntpc_pkg.sv
package ntpc_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SERVER_IP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVER_PORT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_OPCODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SENDS      = 3'd4;

    // register reset values
    localparam logic [7:0] RETRY_INTERVAL_RST = 8'd2;
    localparam logic [3:0] MAX_SENDS_RST      = 4'd8;

    // item function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_PKT   = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // probe and reply step codes
    localparam logic [1:0] STEP_REQ1 = 2'd0;
    localparam logic [1:0] STEP_REQ2 = 2'd1;
    localparam logic [1:0] STEP_FULL = 2'd2;

    // nat type codes
    localparam logic [1:0] NAT_UNCHECKED  = 2'd0;
    localparam logic [1:0] NAT_SYMMETRIC  = 2'd1;
    localparam logic [1:0] NAT_FULL_CONE  = 2'd2;
    localparam logic [1:0] NAT_RESTRICTED = 2'd3;

    // probe phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_REQ1 = 4'b0010,
        PH_REQ2 = 4'b0100,
        PH_FULL = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [31:0] server_ip;
        logic [15:0] server_port;
        logic [7:0]  detect_opcode;
        logic [7:0]  retry_interval;
        logic [3:0]  max_sends;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] saved_ip;
        logic [15:0] saved_port;
        logic [3:0]  tries_left;
        logic [7:0]  countdown;
        logic [1:0]  decided_type;
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic        pkt_len_ok;
        logic [7:0]  pkt_opt;
        logic [1:0]  pkt_step;
        logic [31:0] mapped_ip;
        logic [15:0] mapped_port;
    } t_in_item;

    typedef struct packed {
        logic        send_valid;
        logic [1:0]  send_step;
        logic [15:0] send_port;
        logic [1:0]  nat_kind;
    } t_out_item;

endpackage

// File: design/ntpc_in_if.sv
interface ntpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic        pkt_len_ok;
    logic [7:0]  pkt_opt;
    logic [1:0]  pkt_step;
    logic [31:0] mapped_ip;
    logic [15:0] mapped_port;

    modport source (
        output valid, func, src_ip, src_port, pkt_len_ok, pkt_opt, pkt_step,
               mapped_ip, mapped_port,
        input  ready
    );
    modport sink (
        input  valid, func, src_ip, src_port, pkt_len_ok, pkt_opt, pkt_step,
               mapped_ip, mapped_port,
        output ready
    );
endinterface

// File: design/ntpc_out_if.sv
interface ntpc_out_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [1:0]  send_step;
    logic [15:0] send_port;
    logic [1:0]  nat_kind;

    modport source (
        output valid, send_valid, send_step, send_port, nat_kind,
        input  ready
    );
    modport sink (
        input  valid, send_valid, send_step, send_port, nat_kind,
        output ready
    );
endinterface

// File: design/ntpc_decide.sv
module ntpc_decide (
    input  ntpc_pkg::t_cfg      i_cfg,
    input  ntpc_pkg::t_state    i_state,
    input  ntpc_pkg::t_in_item  i_item,
    output ntpc_pkg::t_state    o_state,
    output ntpc_pkg::t_out_item o_result
);
    import ntpc_pkg::*;

    logic       do_issue;
    logic [1:0] issue_sel;
    logic [3:0] tries_base;
    logic [7:0] cd_dec;
    logic       pkt_ok;

    assign pkt_ok = i_item.pkt_len_ok && (i_item.pkt_opt == i_cfg.detect_opcode);
    assign cd_dec = (i_state.countdown != 8'd0) ? i_state.countdown - 8'd1
                                                : i_state.countdown;

    always_comb begin
        o_state    = i_state;
        o_result   = '0;
        do_issue   = 1'b0;
        issue_sel  = STEP_REQ1;
        tries_base = i_state.tries_left;

        // event handling
        unique case (i_item.func)
            FUNC_START: begin
                o_state.decided_type = NAT_UNCHECKED;
                tries_base = i_cfg.max_sends;
                do_issue   = 1'b1;
                issue_sel  = STEP_REQ1;
            end
            FUNC_PKT: begin
                if (pkt_ok) begin
                    priority if (i_item.pkt_step == STEP_REQ1 && i_state.phase == PH_REQ1) begin
                        o_state.saved_ip   = i_item.mapped_ip;
                        o_state.saved_port = i_item.mapped_port;
                        tries_base = i_cfg.max_sends;
                        do_issue   = 1'b1;
                        issue_sel  = STEP_REQ2;
                    end else if (i_item.pkt_step == STEP_REQ2
                                 && i_state.phase == PH_REQ2) begin
                        if (i_item.mapped_ip == i_state.saved_ip
                            && i_item.mapped_port == i_state.saved_port) begin
                            tries_base = i_cfg.max_sends;
                            do_issue   = 1'b1;
                            issue_sel  = STEP_FULL;
                        end else begin
                            o_state.decided_type = NAT_SYMMETRIC;
                            o_result.nat_kind    = NAT_SYMMETRIC;
                        end
                    end else if (i_item.pkt_step == STEP_FULL
                                 && i_state.phase == PH_FULL) begin
                        if (i_item.src_ip == i_cfg.server_ip
                            && i_item.src_port == i_cfg.server_port + 16'd2) begin
                            o_state.decided_type = NAT_FULL_CONE;
                            o_result.nat_kind    = NAT_FULL_CONE;
                        end
                    end else begin
                        // reply not matching the outstanding probe
                    end
                end
            end
            FUNC_TICK: begin
                if (i_state.decided_type != NAT_UNCHECKED) begin
                    o_result.nat_kind = i_state.decided_type;
                end else begin
                    o_state.countdown = cd_dec;
                    if (cd_dec == 8'd0 && i_state.phase != PH_IDLE) begin
                        if (i_state.tries_left == 4'd0) begin
                            o_state.decided_type = (i_state.phase == PH_FULL)
                                                   ? NAT_RESTRICTED : NAT_SYMMETRIC;
                            o_result.nat_kind    = o_state.decided_type;
                        end else begin
                            do_issue = 1'b1;
                            unique case (i_state.phase)
                                PH_REQ2: issue_sel = STEP_REQ2;
                                PH_FULL: issue_sel = STEP_FULL;
                                default: issue_sel = STEP_REQ1;
                            endcase
                        end
                    end
                end
            end
            default: begin
                // unknown function: no change, all-zero result
            end
        endcase

        // probe send: rearm countdown, use one try
        if (do_issue) begin
            unique case (issue_sel)
                STEP_REQ2: o_state.phase = PH_REQ2;
                STEP_FULL: o_state.phase = PH_FULL;
                default:   o_state.phase = PH_REQ1;
            endcase
            o_state.countdown  = i_cfg.retry_interval;
            o_state.tries_left = (tries_base != 4'd0) ? tries_base - 4'd1 : 4'd0;
            o_result.send_valid = 1'b1;
            o_result.send_step  = issue_sel;
            o_result.send_port  = (issue_sel == STEP_REQ2) ? i_cfg.server_port + 16'd1
                                                           : i_cfg.server_port;
        end
    end

endmodule

// File: design/nat_type_probe_client.sv
// nat type probe client core
//
// input channel i_in carries one event item: start, received packet or
// one-second tick. output channel o_out returns exactly one result item per
// input item: a probe to send (step and destination port), the nat type
// decided, or neither, in input order.
// configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user
// must write it only while the block holds no items; the block does not enforce it.
//
// an accepted item lands in the input register; once the result register is free
// or draining, the decision logic updates the probe state and loads the result
// register. one item per cycle is sustained while the receiver does not stall;
// the rate is set by the single state update path between the two registers.
//
// reset (i_rst_n low, synchronous) empties both registers, loads register
// defaults (retry interval 2, max sends 8) and returns to idle with eight tries.
// when the receiver stalls, the result is held and the input register keeps
// its item; i_in.ready drops only while both stages are full.
module nat_type_probe_client_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ntpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ntpc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ntpc_in_if.sink                          i_in,
    ntpc_out_if.source                       o_out
);
    import ntpc_pkg::*;

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      r_out_valid;
    logic      advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.server_ip      <= '0;
            r_cfg.server_port    <= '0;
            r_cfg.detect_opcode  <= '0;
            r_cfg.retry_interval <= RETRY_INTERVAL_RST;
            r_cfg.max_sends      <= MAX_SENDS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SERVER_IP:      r_cfg.server_ip      <= i_cfg_data[31:0];
                REG_SERVER_PORT:    r_cfg.server_port    <= i_cfg_data[15:0];
                REG_DETECT_OPCODE:  r_cfg.detect_opcode  <= i_cfg_data[7:0];
                REG_RETRY_INTERVAL: r_cfg.retry_interval <= i_cfg_data[7:0];
                REG_MAX_SENDS:      r_cfg.max_sends      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item.func        <= i_in.func;
            r_in_item.src_ip      <= i_in.src_ip;
            r_in_item.src_port    <= i_in.src_port;
            r_in_item.pkt_len_ok  <= i_in.pkt_len_ok;
            r_in_item.pkt_opt     <= i_in.pkt_opt;
            r_in_item.pkt_step    <= i_in.pkt_step;
            r_in_item.mapped_ip   <= i_in.mapped_ip;
            r_in_item.mapped_port <= i_in.mapped_port;
        end
    end

    // probe decision logic
    ntpc_decide u_decide (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    // probe state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.saved_ip     <= '0;
            r_state.saved_port   <= '0;
            r_state.tries_left   <= MAX_SENDS_RST;
            r_state.countdown    <= '0;
            r_state.decided_type <= NAT_UNCHECKED;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.send_valid = r_out_item.send_valid;
    assign o_out.send_step  = r_out_item.send_step;
    assign o_out.send_port  = r_out_item.send_port;
    assign o_out.nat_kind   = r_out_item.nat_kind;

endmodule

// File: design/ntpc_checker.sv
module ntpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_send_valid,
    input logic [1:0]  i_send_step,
    input logic [15:0] i_send_port,
    input logic [1:0]  i_nat_kind
);
    import ntpc_pkg::*;

    // stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_send_valid)
            && $stable(i_send_step) && $stable(i_send_port) && $stable(i_nat_kind))
        else $error("result item changed while stalled");

    // no probe means zero step and port
    a_idle_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_send_valid |-> i_send_step == STEP_REQ1 && i_send_port == 16'd0)
        else $error("send fields set without a probe");

    // probe step is a known code
    a_step_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_send_valid |-> i_send_step == STEP_REQ1
            || i_send_step == STEP_REQ2 || i_send_step == STEP_FULL)
        else $error("bad probe step");

    // a probe send never reports a decision
    a_send_no_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_send_valid |-> i_nat_kind == NAT_UNCHECKED)
        else $error("probe and decision in one item");

    // output empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

endmodule

bind nat_type_probe_client_core ntpc_checker u_ntpc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_send_valid (o_out.send_valid),
    .i_send_step  (o_out.send_step),
    .i_send_port  (o_out.send_port),
    .i_nat_kind   (o_out.nat_kind)
);

// File: tb/sv/tb_nat_type_probe_client_core.sv
module tb_nat_type_probe_client_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ntpc_pkg::*;

    // codes the package leaves out: unused function and an unknown reply step
    localparam logic [1:0] FUNC_NONE  = 2'd3;
    localparam logic [1:0] STEP_OTHER = 2'd3;

    localparam int STALL_LIMIT   = 2000;
    localparam int SESSION_ITEMS = 245;
    localparam int DRAIN_CYCLES  = 4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ntpc_in_if  in_ch ();
    ntpc_out_if out_ch ();

    nat_type_probe_client_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // probe client mirror: settings, probe state and results still owed
    t_cfg      probe_cfg;
    t_state    probe_st;
    t_out_item due_results[$];

    int mismatches  = 0;
    int idle_cycles = 0;
    bit no_idle     = 1'b0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_cfg make_cfg(logic [31:0] ip, logic [15:0] port, logic [7:0] opcode,
                                      logic [7:0] retry, logic [3:0] sends);
        t_cfg c;
        c.server_ip      = ip;
        c.server_port    = port;
        c.detect_opcode  = opcode;
        c.retry_interval = retry;
        c.max_sends      = sends;
        return c;
    endfunction

    // send probe sel: arm the retry countdown and use up one try
    function automatic t_out_item launch_probe(logic [1:0] sel);
        t_out_item r;
        r = '0;
        case (sel)
            STEP_REQ1: probe_st.phase = PH_REQ1;
            STEP_REQ2: probe_st.phase = PH_REQ2;
            default:   probe_st.phase = PH_FULL;
        endcase
        probe_st.countdown = probe_cfg.retry_interval;
        if (probe_st.tries_left != 4'd0) begin
            probe_st.tries_left = probe_st.tries_left - 4'd1;
        end
        r.send_valid = 1'b1;
        r.send_step  = sel;
        r.send_port  = (sel == STEP_REQ2) ? probe_cfg.server_port + 16'd1
                                          : probe_cfg.server_port;
        return r;
    endfunction

    // next probe action and nat verdict for one event
    function automatic t_out_item probe_decide(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.func)
            FUNC_START: begin
                probe_st.tries_left   = probe_cfg.max_sends;
                probe_st.decided_type = NAT_UNCHECKED;
                r = launch_probe(STEP_REQ1);
            end
            FUNC_PKT: begin
                if (it.pkt_len_ok && it.pkt_opt == probe_cfg.detect_opcode) begin
                    if (it.pkt_step == STEP_REQ1 && probe_st.phase == PH_REQ1) begin
                        probe_st.saved_ip   = it.mapped_ip;
                        probe_st.saved_port = it.mapped_port;
                        probe_st.tries_left = probe_cfg.max_sends;
                        r = launch_probe(STEP_REQ2);
                    end else if (it.pkt_step == STEP_REQ2 && probe_st.phase == PH_REQ2) begin
                        if (it.mapped_ip == probe_st.saved_ip &&
                            it.mapped_port == probe_st.saved_port) begin
                            probe_st.tries_left = probe_cfg.max_sends;
                            r = launch_probe(STEP_FULL);
                        end else begin
                            probe_st.decided_type = NAT_SYMMETRIC;
                            r.nat_kind = NAT_SYMMETRIC;
                        end
                    end else if (it.pkt_step == STEP_FULL && probe_st.phase == PH_FULL &&
                                 it.src_ip == probe_cfg.server_ip &&
                                 it.src_port == 16'(probe_cfg.server_port + 16'd2)) begin
                        probe_st.decided_type = NAT_FULL_CONE;
                        r.nat_kind = NAT_FULL_CONE;
                    end
                end
            end
            FUNC_TICK: begin
                if (probe_st.decided_type != NAT_UNCHECKED) begin
                    r.nat_kind = probe_st.decided_type;
                end else begin
                    if (probe_st.countdown != 8'd0) begin
                        probe_st.countdown = probe_st.countdown - 8'd1;
                    end
                    if (probe_st.countdown == 8'd0 && probe_st.phase != PH_IDLE) begin
                        if (probe_st.tries_left == 4'd0) begin
                            probe_st.decided_type = (probe_st.phase == PH_FULL) ? NAT_RESTRICTED
                                                                                : NAT_SYMMETRIC;
                            r.nat_kind = probe_st.decided_type;
                        end else begin
                            case (probe_st.phase)
                                PH_REQ1: r = launch_probe(STEP_REQ1);
                                PH_REQ2: r = launch_probe(STEP_REQ2);
                                default: r = launch_probe(STEP_FULL);
                            endcase
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // item builders
    function automatic t_in_item noise_item();
        t_in_item it;
        it.func        = 2'($urandom_range(0, 3));
        it.src_ip      = $urandom();
        it.src_port    = 16'($urandom_range(0, 65535));
        it.pkt_len_ok  = 1'($urandom_range(0, 1));
        it.pkt_opt     = 8'($urandom_range(0, 255));
        it.pkt_step    = 2'($urandom_range(0, 3));
        it.mapped_ip   = $urandom();
        it.mapped_port = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic t_in_item event_item(logic [1:0] f);
        t_in_item it;
        it = noise_item();
        it.func = f;
        return it;
    endfunction

    function automatic t_in_item reply_item(logic [1:0] step, logic [31:0] sip, logic [15:0] sport,
                                            logic [31:0] mip, logic [15:0] mport);
        t_in_item it;
        it = noise_item();
        it.func        = FUNC_PKT;
        it.pkt_len_ok  = 1'b1;
        it.pkt_opt     = probe_cfg.detect_opcode;
        it.pkt_step    = step;
        it.src_ip      = sip;
        it.src_port    = sport;
        it.mapped_ip   = mip;
        it.mapped_port = mport;
        return it;
    endfunction

    // a reply to the probe now outstanding, sometimes with one bit off
    function automatic t_in_item answer_item();
        logic [31:0] ip;
        logic [15:0] port;
        bit          spoil;
        spoil = ($urandom_range(0, 99) < 35);
        case (probe_st.phase)
            PH_REQ1: begin
                return reply_item(STEP_REQ1, $urandom(), 16'($urandom_range(0, 65535)),
                                  $urandom(), 16'($urandom_range(0, 65535)));
            end
            PH_REQ2: begin
                ip   = probe_st.saved_ip;
                port = probe_st.saved_port;
                if (spoil && $urandom_range(0, 1)) ip = ip ^ (32'd1 << $urandom_range(0, 31));
                else if (spoil) port = port ^ (16'd1 << $urandom_range(0, 15));
                return reply_item(STEP_REQ2, $urandom(), 16'($urandom_range(0, 65535)),
                                  ip, port);
            end
            default: begin
                ip   = probe_cfg.server_ip;
                port = probe_cfg.server_port + 16'd2;
                if (spoil && $urandom_range(0, 1)) ip = ip ^ (32'd1 << $urandom_range(0, 31));
                else if (spoil) port = port ^ (16'd1 << $urandom_range(0, 15));
                return reply_item(STEP_FULL, ip, port, $urandom(),
                                  16'($urandom_range(0, 65535)));
            end
        endcase
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // present one item, wait for acceptance, then record what it must produce
    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.func        <= it.func;
        in_ch.src_ip      <= it.src_ip;
        in_ch.src_port    <= it.src_port;
        in_ch.pkt_len_ok  <= it.pkt_len_ok;
        in_ch.pkt_opt     <= it.pkt_opt;
        in_ch.pkt_step    <= it.pkt_step;
        in_ch.mapped_ip   <= it.mapped_ip;
        in_ch.mapped_port <= it.mapped_port;
        in_ch.valid       <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        due_results.push_back(probe_decide(it));
    endtask

    // stop sending and let every owed result come back
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(t_cfg c);
        settle();
        @(negedge i_clk);
        write_reg(REG_SERVER_IP, c.server_ip);
        write_reg(REG_SERVER_PORT, 32'(c.server_port));
        write_reg(REG_DETECT_OPCODE, 32'(c.detect_opcode));
        write_reg(REG_RETRY_INTERVAL, 32'(c.retry_interval));
        write_reg(REG_MAX_SENDS, 32'(c.max_sends));
        i_cfg_we <= 1'b0;
        probe_cfg = c;
    endtask

    // reset defaults in use before any write
    task automatic test_reset_defaults();
        send_item(event_item(FUNC_START));
        send_item(event_item(FUNC_TICK));
        send_item(event_item(FUNC_TICK));
    endtask

    // full walk through every phase, verdict and ignore rule, port wrap at the top
    task automatic test_directed_walk();
        t_in_item it;
        apply_settings(make_cfg(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'd1, 4'd2));
        send_item(event_item(FUNC_NONE));
        send_item(event_item(FUNC_TICK));
        send_item(event_item(FUNC_START));
        it = reply_item(STEP_REQ1, $urandom(), 16'h0, 32'h0, 16'h0);
        it.pkt_len_ok = 1'b0;
        send_item(it);
        it = reply_item(STEP_REQ1, $urandom(), 16'h0, 32'h0, 16'h0);
        it.pkt_opt = 8'h00;
        send_item(it);
        send_item(reply_item(STEP_REQ2, $urandom(), 16'h0, 32'h0, 16'h0));
        // retry once, then out of tries in the first phase
        send_item(event_item(FUNC_TICK));
        send_item(event_item(FUNC_TICK));
        send_item(event_item(FUNC_TICK));
        // late first reply still acts, then a changed mapping
        send_item(reply_item(STEP_REQ1, $urandom(), 16'h0, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(reply_item(STEP_REQ2, $urandom(), 16'h0, 32'h0, 16'h0));
        // matching mapping, then restricted after full-cone retries
        send_item(event_item(FUNC_START));
        send_item(reply_item(STEP_REQ1, $urandom(), 16'h0, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(reply_item(STEP_REQ2, $urandom(), 16'h0, probe_st.saved_ip,
                             probe_st.saved_port));
        send_item(reply_item(STEP_FULL, 32'hFFFF_FFFF, 16'h0002, 32'h0, 16'h0));
        send_item(reply_item(STEP_OTHER, 32'hFFFF_FFFF, 16'h0001, 32'h0, 16'h0));
        send_item(event_item(FUNC_TICK));
        send_item(event_item(FUNC_TICK));
        // full cone from server port plus two
        send_item(event_item(FUNC_START));
        send_item(reply_item(STEP_REQ1, $urandom(), 16'h0, $urandom(), 16'h1234));
        send_item(reply_item(STEP_REQ2, $urandom(), 16'h0, probe_st.saved_ip,
                             probe_st.saved_port));
        send_item(reply_item(STEP_FULL, 32'hFFFF_FFFF, 16'h0001, 32'h0, 16'h0));
        send_item(event_item(FUNC_TICK));
    endtask

    // zero retry interval and zero tries: the first tick decides
    task automatic test_zero_settings();
        apply_settings(make_cfg(32'h0, 16'h0, 8'h00, 8'd0, 4'd0));
        send_item(event_item(FUNC_START));
        send_item(event_item(FUNC_TICK));
        send_item(event_item(FUNC_START));
        send_item(reply_item(STEP_REQ1, $urandom(), 16'h0, 32'h0, 16'h0));
        send_item(event_item(FUNC_TICK));
    endtask

    // random sessions under several settings, mostly well-formed exchanges
    task automatic test_random_sessions();
        t_in_item it;
        int       r;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: apply_settings(make_cfg($urandom(), 16'($urandom_range(0, 65535)),
                                           8'($urandom_range(0, 255)), 8'd1, 4'd1));
                1: apply_settings(make_cfg($urandom(), 16'hFFFE, 8'($urandom_range(0, 255)),
                                           8'd2, 4'd15));
                2: apply_settings(make_cfg(32'h0, 16'h0, 8'h00, 8'($urandom_range(1, 4)),
                                           4'($urandom_range(1, 4))));
                3: apply_settings(make_cfg(32'hFFFF_FFFF, 16'($urandom_range(0, 65535)),
                                           8'hFF, 8'd255, 4'd3));
                default: apply_settings(make_cfg($urandom(), 16'hFFFF,
                                                 8'($urandom_range(0, 255)),
                                                 8'($urandom_range(1, 3)),
                                                 4'($urandom_range(1, 15))));
            endcase
            no_idle = (p == 1);
            for (int n = 0; n < SESSION_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (probe_st.phase == PH_IDLE ||
                    (probe_st.decided_type != NAT_UNCHECKED && r < 40)) begin
                    it = event_item(FUNC_START);
                end else if (r < 6) begin
                    it = noise_item();
                end else if (r < 12) begin
                    // broken reply: short packet or wrong opcode
                    it = answer_item();
                    if ($urandom_range(0, 1)) it.pkt_len_ok = 1'b0;
                    else it.pkt_opt = it.pkt_opt ^ 8'($urandom_range(1, 255));
                end else if (r < 48) begin
                    it = event_item(FUNC_TICK);
                end else if (r < 53) begin
                    it = reply_item(2'($urandom_range(0, 3)), probe_cfg.server_ip,
                                    probe_cfg.server_port + 16'd2, $urandom(),
                                    16'($urandom_range(0, 65535)));
                end else begin
                    it = answer_item();
                end
                send_item(it);
            end
            no_idle = 1'b0;
        end
    endtask

    // result receiver with random stalls
    initial begin
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else if (!no_idle && $urandom_range(0, 99) < 18) begin
                out_ch.ready <= 1'b0;
                hold = pick_gap();
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch %s: expected %0h, got %0h at %0t", name, want, got, $realtime);
            end
        end
    endfunction

    // compare each result with the oldest owed one
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result item at %0t", $realtime);
                end
            end else begin
                want = due_results.pop_front();
                check_field("send_valid", 16'(want.send_valid), 16'(out_ch.send_valid));
                check_field("send_step", 16'(want.send_step), 16'(out_ch.send_step));
                check_field("send_port", want.send_port, out_ch.send_port);
                check_field("nat_kind", 16'(want.nat_kind), 16'(out_ch.nat_kind));
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // reset, then the tests in turn
    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.func        = FUNC_START;
        in_ch.src_ip      = '0;
        in_ch.src_port    = '0;
        in_ch.pkt_len_ok  = 1'b0;
        in_ch.pkt_opt     = '0;
        in_ch.pkt_step    = STEP_REQ1;
        in_ch.mapped_ip   = '0;
        in_ch.mapped_port = '0;

        probe_cfg = make_cfg(32'h0, 16'h0, 8'h00, RETRY_INTERVAL_RST, MAX_SENDS_RST);
        probe_st.phase        = PH_IDLE;
        probe_st.saved_ip     = '0;
        probe_st.saved_port   = '0;
        probe_st.tries_left   = MAX_SENDS_RST;
        probe_st.countdown    = '0;
        probe_st.decided_type = NAT_UNCHECKED;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_walk();
        test_zero_settings();
        test_random_sessions();

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
